// File: rtl/core/modbus_rtu_slave_frame_engine_assert.svh
`ifndef MODBUS_RTU_SLAVE_FRAME_ENGINE_ASSERT_SVH
`define MODBUS_RTU_SLAVE_FRAME_ENGINE_ASSERT_SVH

// same-cycle implication
`define MBSFE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MBSFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mbsfe_pkg.sv
`timescale 1ns / 1ps

package mbsfe_pkg;

	localparam int NUM_REGS_DEF    = 128;
	localparam int FRAME_BYTES_DEF = 256;
	localparam int LEN_W           = 9;
	localparam int CNT_W           = 7;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] COIL_ON   = 16'hFF00;
	localparam logic [7:0]  FC_READ   = 8'h03;
	localparam logic [7:0]  FC_COIL   = 8'h05;
	localparam logic [7:0]  FC_REG    = 8'h06;
	localparam logic [6:0]  MAX_READ  = 7'd125;
	localparam logic [6:0]  LEVEL_MAX = 7'd100;
	localparam logic [15:0] LEVEL_SAT = 16'd1010;
	localparam logic [LEN_W-1:0] MIN_FRAME = 9'd8;

	typedef enum logic [1:0] {
		OP_RX   = 2'd0,
		OP_GAP  = 2'd1,
		OP_PULL = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_ADDR  = 3'd2,
		ST_CRC   = 3'd3,
		ST_FUNC  = 3'd4,
		ST_OVFL  = 3'd5
	} frame_status_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_ECHO = 2'd1,
		MODE_READ = 2'd2
	} tx_mode_t;

	typedef struct packed {
		logic             en;
		logic [LEN_W-1:0] addr;
		logic [7:0]       data;
	} fb_wr_t;

	typedef struct packed {
		logic        en;
		logic [15:0] addr;
		logic [15:0] data;
	} hreg_wr_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/core/mbsfe_fbuf.sv
`timescale 1ns / 1ps

module mbsfe_fbuf #(
	parameter int FRAME_BYTES = mbsfe_pkg::FRAME_BYTES_DEF
) (
	input  logic                         clk,
	input  mbsfe_pkg::fb_wr_t            wr,
	input  logic [mbsfe_pkg::LEN_W-1:0]  rd_addr,
	output logic [7:0]                   rd_data
);
	import mbsfe_pkg::*;

	localparam int FBW = $clog2(FRAME_BYTES);

	logic [7:0] mem [FRAME_BYTES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[FBW-1:0]] <= wr.data;
		end
		rd_data <= mem[rd_addr[FBW-1:0]];
	end

endmodule

// File: rtl/core/mbsfe_hregs.sv
`timescale 1ns / 1ps

module mbsfe_hregs #(
	parameter int NUM_REGS = mbsfe_pkg::NUM_REGS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mbsfe_pkg::hreg_wr_t           wr,
	input  logic [$clog2(NUM_REGS)-1:0]   rd_addr,
	output logic [15:0]                   rd_data
);
	import mbsfe_pkg::*;

	localparam int AW = $clog2(NUM_REGS);
	localparam logic [AW:0] NUM_L = NUM_REGS[AW:0];

	logic [15:0]         mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic                wr_ok;
	logic                rd_ok;

	assign wr_ok = wr.en && (wr.addr < 16'(NUM_REGS));
	assign rd_ok = {1'b0, rd_addr} < NUM_L;

	// entry not yet written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_ok) begin
			valid_q[wr.addr[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
		rd_data <= (rd_ok && valid_q[rd_addr]) ? mem[rd_addr] : 16'd0;
	end

endmodule

// File: rtl/core/modbus_rtu_slave_frame_engine.sv
`timescale 1ns / 1ps
// channel   | dir | signals                          | contents
// s_        | in  | s_tvalid s_tready s_tdata s_tuser | rx_byte, op
// m_        | out | m_tvalid m_tready m_tdata m_tlast | status, command, tx byte
// cfg_      | in  | cfg_wen cfg_wdata                 | slave_address
// one item per cycle while s_tready is high; every item is finished in the cycle it is
// accepted, and a gap or pull result sits in the output register the next cycle
// frame buffer and holding registers are read ahead, addressed from the next tx position
// arst_n clears control state and all holding registers at once (per-entry valid bits)
// the input stalls only while a result waits in the output register and m_tready is low

`include "modbus_rtu_slave_frame_engine_assert.svh"

module modbus_rtu_slave_frame_engine #(
	parameter int NUM_REGS    = mbsfe_pkg::NUM_REGS_DEF,
	parameter int FRAME_BYTES = mbsfe_pkg::FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte[7:0]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// frame_status[2:0] status_valid[3] cmd_valid[4] cmd_kind[5] cmd_device[21:6]
	// cmd_power[22] cmd_level[29:23] tx_valid[30] tx_byte[38:31] zero[39]
	output logic [39:0] m_tdata,
	output logic        m_tlast,   // tx_last
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata
);
	import mbsfe_pkg::*;

	localparam int AW = $clog2(NUM_REGS);
	localparam logic [LEN_W-1:0] FB_L = LEN_W'(FRAME_BYTES);
	localparam logic [16:0] NUM_L = 17'(NUM_REGS);

	logic [7:0]       slave_addr_q;
	logic [7:0]       hdr_q [6];
	logic [7:0]       hdr_d [6];
	logic [LEN_W-1:0] frame_len_q, frame_len_d;
	logic [15:0]      crc_q, crc_d;
	tx_mode_t         mode_q, mode_d;
	logic [LEN_W-1:0] tx_index_q, tx_index_d;
	logic [LEN_W-1:0] tx_len_q, tx_len_d;
	logic [15:0]      tx_crc_q, tx_crc_d;
	logic [AW-1:0]    read_start_q, read_start_d;
	logic [CNT_W-1:0] read_count_q, read_count_d;

	fb_wr_t           fb_wr;
	hreg_wr_t         hr_wr;
	logic [7:0]       fb_rd;
	logic [15:0]      hr_rd;
	logic [AW-1:0]    hr_rd_addr;
	logic [LEN_W-1:0] rd_ofs;

	logic             accept;
	op_t              op;
	logic             res_valid;
	frame_status_t    status;
	logic             status_valid, cmd_valid, cmd_kind, cmd_power;
	logic [15:0]      cmd_device;
	logic [6:0]       cmd_level;
	logic             tx_valid, tx_last;
	logic [7:0]       tx_byte;

	logic [15:0]      a_w, v_w;
	logic [6:0]       cap;
	logic [16:0]      room;
	logic [6:0]       cnt;
	logic [17:0]      lvl_prod;
	logic [LEN_W-1:0] body, k;
	logic             on;

	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser);

	assign a_w      = {hdr_q[2], hdr_q[3]};
	assign v_w      = {hdr_q[4], hdr_q[5]};
	assign cap      = (v_w > 16'(MAX_READ)) ? MAX_READ : v_w[6:0];
	assign room     = NUM_L - {1'b0, a_w};
	assign cnt      = (room < 17'(cap)) ? room[6:0] : cap;
	assign lvl_prod = {8'd0, v_w[9:0]} * 18'd205;
	assign on       = (v_w == COIL_ON);
	assign body     = 9'd3 + {1'b0, read_count_q, 1'b0};
	assign k        = tx_index_q - 9'd3;

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			hdr_d[j] = hdr_q[j];
		end
		frame_len_d  = frame_len_q;
		crc_d        = crc_q;
		mode_d       = mode_q;
		tx_index_d   = tx_index_q;
		tx_len_d     = tx_len_q;
		tx_crc_d     = tx_crc_q;
		read_start_d = read_start_q;
		read_count_d = read_count_q;
		fb_wr        = '0;
		hr_wr        = '0;
		res_valid    = 1'b0;
		status       = ST_OK;
		status_valid = 1'b0;
		cmd_valid    = 1'b0;
		cmd_kind     = 1'b0;
		cmd_device   = 16'd0;
		cmd_power    = 1'b0;
		cmd_level    = 7'd0;
		tx_valid     = 1'b0;
		tx_byte      = 8'd0;
		tx_last      = 1'b0;
		if (accept) begin
			case (op)
				OP_RX: begin
					mode_d = MODE_IDLE;
					if (frame_len_q < FB_L) begin
						fb_wr.en    = 1'b1;
						fb_wr.addr  = frame_len_q;
						fb_wr.data  = s_tdata;
						crc_d       = crc_byte(crc_q, s_tdata);
						frame_len_d = frame_len_q + 9'd1;
						if (frame_len_q < 9'd6) begin
							hdr_d[frame_len_q[2:0]] = s_tdata;
						end
					end else begin
						frame_len_d = FB_L + 9'd1;
					end
				end
				OP_GAP: begin
					res_valid    = 1'b1;
					status_valid = 1'b1;
					if (frame_len_q > FB_L) begin
						status = ST_OVFL;
					end else if (frame_len_q < MIN_FRAME) begin
						status = ST_SHORT;
					end else if (hdr_q[0] != slave_addr_q) begin
						status = ST_ADDR;
					end else if (crc_q != 16'd0) begin
						status = ST_CRC;
					end else if (hdr_q[1] != FC_READ && hdr_q[1] != FC_COIL
							&& hdr_q[1] != FC_REG) begin
						status = ST_FUNC;
					end else begin
						status = ST_OK;
					end
					if (status == ST_OK) begin
						tx_index_d = '0;
						tx_crc_d   = CRC_INIT;
						if (hdr_q[1] == FC_READ) begin
							if ({1'b0, a_w} >= NUM_L) begin
								read_start_d = '0;
								read_count_d = '0;
								tx_len_d     = 9'd5;
							end else begin
								read_start_d = a_w[AW-1:0];
								read_count_d = cnt;
								tx_len_d     = 9'd5 + {1'b0, cnt, 1'b0};
							end
							mode_d = MODE_READ;
						end else begin
							cmd_valid  = 1'b1;
							cmd_device = a_w;
							hr_wr.en   = 1'b1;
							hr_wr.addr = a_w;
							if (hdr_q[1] == FC_COIL) begin
								cmd_power  = on;
								hr_wr.data = {15'd0, on};
							end else begin
								cmd_kind   = 1'b1;
								cmd_level  = (v_w >= LEVEL_SAT) ? LEVEL_MAX : lvl_prod[17:11];
								hr_wr.data = v_w;
							end
							tx_len_d = frame_len_q;
							mode_d   = MODE_ECHO;
						end
					end
					frame_len_d = '0;
					crc_d       = CRC_INIT;
				end
				OP_PULL: begin
					res_valid = 1'b1;
					if (mode_q == MODE_IDLE || tx_index_q >= tx_len_q) begin
						mode_d = MODE_IDLE;
					end else begin
						if (mode_q == MODE_ECHO) begin
							tx_byte = fb_rd;
						end else if (tx_index_q == 9'd0) begin
							tx_byte = hdr_q[0];
						end else if (tx_index_q == 9'd1) begin
							tx_byte = FC_READ;
						end else if (tx_index_q == 9'd2) begin
							tx_byte = {read_count_q, 1'b0};
						end else if (tx_index_q < body) begin
							tx_byte = k[0] ? hr_rd[7:0] : hr_rd[15:8];
						end else if (tx_index_q == body) begin
							tx_byte = tx_crc_q[7:0];
						end else begin
							tx_byte = tx_crc_q[15:8];
						end
						if (mode_q == MODE_READ && tx_index_q < body) begin
							tx_crc_d = crc_byte(tx_crc_q, tx_byte);
						end
						tx_valid   = 1'b1;
						tx_index_d = tx_index_q + 9'd1;
						if (tx_index_d >= tx_len_q) begin
							tx_last = 1'b1;
							mode_d  = MODE_IDLE;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// read one position ahead
	assign rd_ofs     = (tx_index_d - 9'd3) >> 1;
	assign hr_rd_addr = read_start_d + AW'(rd_ofs);

	mbsfe_fbuf #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_fbuf (
		.clk     (clk),
		.wr      (fb_wr),
		.rd_addr (tx_index_d),
		.rd_data (fb_rd)
	);

	mbsfe_hregs #(
		.NUM_REGS(NUM_REGS)
	) u_hregs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (hr_wr),
		.rd_addr (hr_rd_addr),
		.rd_data (hr_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 8'd1;
			frame_len_q  <= '0;
			crc_q        <= CRC_INIT;
			mode_q       <= MODE_IDLE;
			tx_index_q   <= '0;
			tx_len_q     <= '0;
			tx_crc_q     <= CRC_INIT;
			read_start_q <= '0;
			read_count_q <= '0;
			m_tvalid     <= 1'b0;
		end else begin
			if (cfg_wen) begin
				slave_addr_q <= cfg_wdata;
			end
			frame_len_q  <= frame_len_d;
			crc_q        <= crc_d;
			mode_q       <= mode_d;
			tx_index_q   <= tx_index_d;
			tx_len_q     <= tx_len_d;
			tx_crc_q     <= tx_crc_d;
			read_start_q <= read_start_d;
			read_count_q <= read_count_d;
			if (s_tready) begin
				m_tvalid <= accept && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 6; j++) begin
			hdr_q[j] <= hdr_d[j];
		end
		if (accept && res_valid) begin
			m_tdata <= {1'b0, tx_byte, tx_valid, cmd_level, cmd_power, cmd_device,
				cmd_kind, cmd_valid, status_valid, status};
			m_tlast <= tx_last;
		end
	end

	`MBSFE_ASSERT_NOW(a_tx_in_range, mode_q != MODE_IDLE, tx_index_q < tx_len_q,
		"tx position past response end")
	`MBSFE_ASSERT_NOW(a_len_bound, 1'b1, frame_len_q <= FB_L + 9'd1,
		"frame length beyond overflow mark")
	`MBSFE_ASSERT_NEXT(a_rx_kills_tx, accept && op == OP_RX, mode_q == MODE_IDLE,
		"response survived a received byte")
	`MBSFE_ASSERT_NOW(a_read_cap, mode_q == MODE_READ, read_count_q <= MAX_READ,
		"read count above cap")

endmodule
